@@ rtl/core/sitbd_pkg.sv @@
// ----------------------------------------------------------------------------
// sitbd_pkg
// types and constants shared by the integer-to-digits core
// ----------------------------------------------------------------------------
package sitbd_pkg;

    localparam int SYM_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int BASE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CHUNK_W    = 8;

    localparam logic [SYM_W-1:0]  MINUS_SIGN     = 8'h2D;
    localparam logic [BASE_W-1:0] BASE_RESET     = 5'd10;
    localparam logic [63:0]       DIGITS_LO_RESET = 64'd3978425819141910832;
    localparam logic [63:0]       DIGITS_HI_RESET = 64'd14648;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_0_7 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_8_15 = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               digit_valid;
        logic               done;
        logic [DIGIT_W-1:0] digit;
    } div_status_t;

    function automatic logic [SYM_W-1:0] symbol_of(
        input logic [63:0]        lo,
        input logic [63:0]        hi,
        input logic [DIGIT_W-1:0] d
    );
        logic [SYM_W-1:0] s;
        if (d[3])
        begin
            s = hi[8*d[2:0] +: 8];
        end
        else
        begin
            s = lo[8*d[2:0] +: 8];
        end
        return s;
    endfunction

endpackage

@@ rtl/core/sitbd_store.sv @@
// ----------------------------------------------------------------------------
// sitbd_store
// digit memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module sitbd_store
    import sitbd_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [DIGIT_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [DIGIT_W-1:0] rd_data
);

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sitbd_div.sv @@
// ----------------------------------------------------------------------------
// sitbd_div
// repeated division by the base, one byte of the dividend per cycle
// ----------------------------------------------------------------------------
module sitbd_div
    import sitbd_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] magnitude,
    input  logic [BASE_W-1:0]     base,
    output div_status_t           status
);

    localparam int CHUNKS = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int MAG_W  = CHUNKS * CHUNK_W;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    logic [MAG_W-1:0]  q_reg, q_next;
    logic [BASE_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [BASE_W-1:0]  r;
    logic [BASE_W:0]    t;
    logic [CHUNK_W-1:0] qb;
    logic [CHUNK_W-1:0] byte_in;
    logic [MAG_W-1:0]   q_shift;
    logic               last_chunk;

    // restoring long division of one byte
    always_comb
    begin
        byte_in = q_reg[MAG_W-1 -: CHUNK_W];
        r       = rem_reg;
        qb      = '0;
        t       = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            t = {r, byte_in[i]};
            if (t >= {1'b0, base})
            begin
                t     = t - {1'b0, base};
                qb[i] = 1'b1;
            end
            r = t[BASE_W-1:0];
        end
    end

    assign q_shift    = (q_reg << CHUNK_W) | MAG_W'(qb);
    assign last_chunk = (cnt_reg == CNT_W'(CHUNKS - 1));

    always_comb
    begin
        q_next             = q_reg;
        rem_next           = rem_reg;
        cnt_next           = cnt_reg;
        busy_next          = busy_reg;
        status.digit_valid = 1'b0;
        status.done        = 1'b0;
        status.digit       = r[DIGIT_W-1:0];
        if (start)
        begin
            q_next    = MAG_W'(magnitude);
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = q_shift;
            if (last_chunk)
            begin
                status.digit_valid = 1'b1;
                status.done        = (q_shift == '0);
                rem_next           = '0;
                cnt_next           = '0;
                busy_next          = (q_shift != '0);
            end
            else
            begin
                rem_next = r;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

@@ rtl/core/signed_integer_to_base_digits_core.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_base_digits_core
// signed integer to text in a configurable radix
// ----------------------------------------------------------------------------
// one beat on s_axis carries a signed integer; the text leaves on m_axis as
// one character per beat: '-' for a negative value, then the digits, most
// significant first, with tlast on the final character. the radix and the
// sixteen digit symbols come from the cfg port; they are to be written only
// while the core idles, a rule for the user that the core does not enforce.
// the digits land in the digit memory and are read back one per cycle while
// m_axis does not stall; the memory has a registered read port, and the text
// streams at one character per cycle. s_axis_tready is high only between
// values, and the next value is taken while the last character still sits in
// the output register. a stall on m_axis holds the output register and the
// read-back pauses behind it. reset restores the default radix ten and the
// digit table "0123456789", and empties the output.
// ----------------------------------------------------------------------------
module signed_integer_to_base_digits_core
    import sitbd_pkg::*;
#(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [SYM_W-1:0]                    m_axis_tdata,   // symbol
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data
);

    localparam int DEPTH = VALUE_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // configuration
    logic [BASE_W-1:0] base_len_reg;
    logic [63:0]       digits_lo_reg;
    logic [63:0]       digits_hi_reg;
    logic [BASE_W-1:0] base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg  <= BASE_RESET;
            digits_lo_reg <= DIGITS_LO_RESET;
            digits_hi_reg <= DIGITS_HI_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_LEN:    base_len_reg  <= cfg_data[BASE_W-1:0];
                REG_DIGITS_0_7:  digits_lo_reg <= cfg_data;
                REG_DIGITS_8_15: digits_hi_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (base_len_reg < BASE_W'(2))
        begin
            base = BASE_W'(2);
        end
        else if (int'(base_len_reg) > MAX_BASE)
        begin
            base = BASE_W'(MAX_BASE);
        end
        else
        begin
            base = base_len_reg;
        end
    end

    // input and sign
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  in_fire;

    assign value     = s_axis_tdata[VALUE_BITS-1:0];
    assign magnitude = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // divider
    div_status_t div_status;

    sitbd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .magnitude (magnitude),
        .base      (base),
        .status    (div_status)
    );

    // control state
    state_t           state_reg, state_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    dcnt_reg, dcnt_next;
    logic [CW-1:0]    rcnt_reg, rcnt_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [DIGIT_W-1:0] rd_data;
    logic               out_free;
    logic               move;

    sitbd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (div_status.digit_valid),
        .wr_addr (dcnt_reg[AW-1:0]),
        .wr_data (div_status.digit),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign move     = pend_reg && out_free;
    assign rd_addr  = AW'(rcnt_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        dcnt_next      = dcnt_reg;
        rcnt_next      = rcnt_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_sym_next   = out_sym_reg;
        rd_en          = 1'b0;
        s_axis_tready  = (state_reg == ST_IDLE);

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = symbol_of(digits_lo_reg, digits_hi_reg, rd_data);
            out_last_next  = pend_last_reg;
            pend_next      = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next   = value[VALUE_BITS-1];
                    dcnt_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.digit_valid)
                begin
                    dcnt_next = dcnt_reg + CW'(1);
                end
                if (div_status.done)
                begin
                    rcnt_next  = dcnt_reg + CW'(1);
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = MINUS_SIGN;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if ((rcnt_reg != '0) && (!pend_reg || move))
                begin
                    rd_en          = 1'b1;
                    rcnt_next      = rcnt_reg - CW'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (rcnt_reg == CW'(1));
                end
                if (move && pend_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            dcnt_reg      <= '0;
            rcnt_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            dcnt_reg      <= dcnt_next;
            rcnt_reg      <= rcnt_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
